[rtl/dpr_pkg.sv]
// Shared types, constants and codes for the debug packet receiver.
package dpr_pkg;

  // Largest buffer the receiver is built for; the parser saturates the payload limit to it
  localparam int MAX_PAYLOAD = 4096;
  localparam int LIMIT_TOP   = (MAX_PAYLOAD < 4096) ? MAX_PAYLOAD : 4096;

  localparam int LIMIT_W = 13;
  localparam int COUNT_W = 12;

  // Result queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Characters of the framing
  localparam logic [7:0] CHAR_START = 8'h24; // '$'
  localparam logic [7:0] CHAR_END   = 8'h23; // '#'
  localparam logic [7:0] CHAR_ACK   = 8'h2b; // '+'
  localparam logic [7:0] CHAR_NAK   = 8'h2d; // '-'
  localparam logic [7:0] CHAR_ZERO  = 8'h30; // '0'
  localparam logic [7:0] CHAR_NINE  = 8'h39; // '9'
  localparam logic [7:0] CHAR_LOW_A = 8'h61; // 'a'
  localparam logic [7:0] HEX_TEN    = 8'd10;

  // Configuration register indexes
  localparam logic CFG_RX_ENABLE     = 1'b0;
  localparam logic CFG_PAYLOAD_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_HEX1    = 2'd2,
    PH_HEX2    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_GOOD = 2'd1,
    KIND_BAD  = 2'd2,
    KIND_OVER = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [7:0]         data;
    logic [COUNT_W-1:0] position;
  } result_t;

  // Up to two result words produced by one received byte
  typedef struct packed {
    logic    v0;
    logic    v1;
    result_t res0;
    result_t res1;
  } push_t;

endpackage

[rtl/debug_packet_receiver.sv]
// Debug packet receiver top level: configuration registers and channel wiring.
//
// Receives serial bytes framed as '$' payload '#' hex hex, one byte per clock at full rate.
// Each accepted byte sits in an input register, where the framing state machine turns it
// into zero, one or two result words that go into a four-entry result queue; the first
// result of a byte is offered after the input register and the queue. Input stalls only
// while the queue has fewer than two free entries, so with the output side never stalling
// the block takes a byte every cycle. Payload bytes come out with their index, a closing
// checksum gives '+' or '-' with the packet length, and a payload that reaches the buffer
// size minus one ends in an overflow drop word right after its last byte. Configuration
// writes are always ready and should be made only while no byte is in flight.
module debug_packet_receiver (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [dpr_pkg::LIMIT_W-1:0]  cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   rx_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   kind,
  output logic [7:0]                   data,
  output logic [dpr_pkg::COUNT_W-1:0]  position
);

  logic                         rx_enable;
  logic [dpr_pkg::LIMIT_W-1:0]  payload_limit;
  logic                         room;
  dpr_pkg::push_t               push;
  dpr_pkg::result_t             head;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rx_enable     <= 1'b0;
      payload_limit <= dpr_pkg::LIMIT_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        dpr_pkg::CFG_RX_ENABLE:     rx_enable     <= cfg_data[0];
        dpr_pkg::CFG_PAYLOAD_LIMIT: payload_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  dpr_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .rx_enable     (rx_enable),
    .payload_limit (payload_limit),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .room          (room),
    .push          (push)
  );

  dpr_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign kind     = head.kind;
  assign data     = head.data;
  assign position = head.position;

endmodule

[rtl/dpr_parser.sv]
// Input register and packet framing state machine of the receiver.
module dpr_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rx_enable,
  input  logic [dpr_pkg::LIMIT_W-1:0]  payload_limit,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   rx_byte,
  input  logic                         room,
  output dpr_pkg::push_t               push
);

  logic                          in_full;
  logic [7:0]                    in_byte;
  logic                          step;
  logic                          accept;

  dpr_pkg::phase_t               phase, phase_next;
  logic [dpr_pkg::COUNT_W-1:0]   payload_count, payload_count_next;
  logic [7:0]                    running_sum, running_sum_next;
  logic                          zero_seen, zero_seen_next;
  logic [7:0]                    high_digit, high_digit_next;

  logic [dpr_pkg::LIMIT_W-1:0]   lim_clamped;
  logic [dpr_pkg::LIMIT_W-1:0]   lim_m1;
  logic [dpr_pkg::COUNT_W-1:0]   count_inc;
  logic                          zero_flag;
  logic [7:0]                    low_digit;
  logic [7:0]                    got_sum;

  function automatic logic [7:0] hex_value(input logic [7:0] c);
    if (c >= dpr_pkg::CHAR_ZERO && c <= dpr_pkg::CHAR_NINE)
      return c - dpr_pkg::CHAR_ZERO;
    return c - dpr_pkg::CHAR_LOW_A + dpr_pkg::HEX_TEN;
  endfunction

  // Hold a word until the queue has room for two results
  assign step     = in_full && room;
  assign in_stall = in_full && !room;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (accept) begin
      in_full <= 1'b1;
    end else if (step) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte <= rx_byte;
    end
  end

  // Saturate the buffer size into its legal range
  always_comb begin
    lim_clamped = payload_limit;
    if (payload_limit < dpr_pkg::LIMIT_W'(2)) begin
      lim_clamped = dpr_pkg::LIMIT_W'(2);
    end else if (payload_limit > dpr_pkg::LIMIT_W'(dpr_pkg::LIMIT_TOP)) begin
      lim_clamped = dpr_pkg::LIMIT_W'(dpr_pkg::LIMIT_TOP);
    end
  end

  assign lim_m1    = lim_clamped - dpr_pkg::LIMIT_W'(1);
  assign count_inc = payload_count + dpr_pkg::COUNT_W'(1);
  assign zero_flag = zero_seen || (in_byte == 8'h00);
  assign low_digit = hex_value(in_byte);
  assign got_sum   = {high_digit[3:0], 4'b0000} | low_digit;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= dpr_pkg::PH_HUNT;
      payload_count <= '0;
      running_sum   <= '0;
      zero_seen     <= 1'b0;
      high_digit    <= '0;
    end else begin
      phase         <= phase_next;
      payload_count <= payload_count_next;
      running_sum   <= running_sum_next;
      zero_seen     <= zero_seen_next;
      high_digit    <= high_digit_next;
    end
  end

  // Next state and result words; drop the byte when disabled
  always_comb begin
    phase_next         = phase;
    payload_count_next = payload_count;
    running_sum_next   = running_sum;
    zero_seen_next     = zero_seen;
    high_digit_next    = high_digit;
    push               = '0;
    if (step && rx_enable) begin
      unique case (phase)
        dpr_pkg::PH_HUNT: begin
          if (in_byte == dpr_pkg::CHAR_START) begin
            phase_next         = dpr_pkg::PH_PAYLOAD;
            payload_count_next = '0;
            running_sum_next   = '0;
            zero_seen_next     = 1'b0;
          end
        end
        dpr_pkg::PH_PAYLOAD: begin
          if (in_byte == dpr_pkg::CHAR_END) begin
            phase_next = dpr_pkg::PH_HEX1;
          end else begin
            push.v0            = 1'b1;
            push.res0.kind     = dpr_pkg::KIND_BYTE;
            push.res0.data     = in_byte;
            push.res0.position = payload_count;
            zero_seen_next     = zero_flag;
            if (!zero_flag) begin
              running_sum_next = running_sum + in_byte;
            end
            payload_count_next = count_inc;
            // Buffer full: report the drop right after this byte
            if ({1'b0, count_inc} >= lim_m1) begin
              push.v1            = 1'b1;
              push.res1.kind     = dpr_pkg::KIND_OVER;
              push.res1.data     = 8'h00;
              push.res1.position = count_inc;
              phase_next         = dpr_pkg::PH_HUNT;
            end
          end
        end
        dpr_pkg::PH_HEX1: begin
          high_digit_next = low_digit;
          phase_next      = dpr_pkg::PH_HEX2;
        end
        dpr_pkg::PH_HEX2: begin
          push.v0            = 1'b1;
          push.res0.position = payload_count;
          if (got_sum == running_sum) begin
            push.res0.kind = dpr_pkg::KIND_GOOD;
            push.res0.data = dpr_pkg::CHAR_ACK;
          end else begin
            push.res0.kind = dpr_pkg::KIND_BAD;
            push.res0.data = dpr_pkg::CHAR_NAK;
          end
          phase_next = dpr_pkg::PH_HUNT;
        end
        default: begin
          phase_next = dpr_pkg::PH_HUNT;
        end
      endcase
    end
  end

  // A second result is always an overflow drop that ends the packet
  assert property (@(posedge clk) disable iff (rst)
    push.v1 |-> (push.v0 && push.res1.kind == dpr_pkg::KIND_OVER &&
                 phase_next == dpr_pkg::PH_HUNT))
    else $error("second result is not an overflow drop");

  // Nothing is emitted while hunting for the start character
  assert property (@(posedge clk) disable iff (rst)
    (phase == dpr_pkg::PH_HUNT) |-> !push.v0)
    else $error("result emitted while hunting");

  // Results only come from a consumed word
  assert property (@(posedge clk) disable iff (rst)
    push.v0 |-> (step && rx_enable))
    else $error("result without a consumed word");

endmodule

[rtl/dpr_out_fifo.sv]
// Small result queue taking up to two words per cycle and giving one per cycle while the output is not stalled.
module dpr_out_fifo (
  input  logic             clk,
  input  logic             rst,
  input  dpr_pkg::push_t   push,
  output logic             room,
  output logic             out_valid,
  input  logic             out_stall,
  output dpr_pkg::result_t head
);

  dpr_pkg::result_t                 entries [dpr_pkg::QUEUE_DEPTH];
  logic [dpr_pkg::QUEUE_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [dpr_pkg::QUEUE_PTR_W-1:0]  wr_ptr_p1;
  logic [dpr_pkg::QUEUE_CNT_W-1:0]  count, count_next;
  logic                             pop;

  assign wr_ptr_p1 = wr_ptr + dpr_pkg::QUEUE_PTR_W'(1);
  assign out_valid = (count != '0);
  assign pop       = out_valid && !out_stall;
  assign head      = entries[rd_ptr];
  assign room      = (count <= dpr_pkg::QUEUE_CNT_W'(dpr_pkg::QUEUE_DEPTH - 2));

  assign count_next = count + dpr_pkg::QUEUE_CNT_W'(push.v0)
                    + dpr_pkg::QUEUE_CNT_W'(push.v1) - dpr_pkg::QUEUE_CNT_W'(pop);

  // Store incoming words
  always_ff @(posedge clk) begin
    if (push.v0) begin
      entries[wr_ptr] <= push.res0;
    end
    if (push.v1) begin
      entries[wr_ptr_p1] <= push.res1;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + dpr_pkg::QUEUE_PTR_W'(push.v0) + dpr_pkg::QUEUE_PTR_W'(push.v1);
      if (pop) begin
        rd_ptr <= rd_ptr + dpr_pkg::QUEUE_PTR_W'(1);
      end
      count <= count_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= dpr_pkg::QUEUE_CNT_W'(dpr_pkg::QUEUE_DEPTH))
    else $error("result queue over capacity");

  assert property (@(posedge clk) disable iff (rst)
    push.v1 |-> push.v0)
    else $error("second word pushed without the first");

  assert property (@(posedge clk) disable iff (rst)
    (pop && !push.v0) |=> (count == $past(count) - dpr_pkg::QUEUE_CNT_W'(1)))
    else $error("queue occupancy did not drop on a read");

endmodule
